// ===== design/nsr_pkg.sv =====
package nsr_pkg;

  localparam int FracBits = 16;
  localparam int RadW     = 32;
  localparam int ScaledW  = RadW + FracBits;
  localparam int SqW      = 2 * RadW;
  localparam int StepW    = 6;
  localparam int TolW     = 32;
  localparam int DivCntW  = $clog2(ScaledW + 1);
  localparam int OutW     = 40;

  localparam logic [2:0] AddrTol = 3'd0;
  localparam logic [2:0] AddrMax = 3'd4;

  localparam logic [TolW-1:0]  TolReset = TolW'(42950);
  localparam logic [StepW-1:0] MaxReset = StepW'(40);

  typedef enum logic [2:0] {
    StIdle,
    StSquare,
    StCompare,
    StDivide,
    StUpdate,
    StFinish
  } state_e;

  typedef struct packed {
    logic load;
    logic square;
    logic div_start;
    logic div_step;
    logic update;
    logic conv_we;
    logic conv_val;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic in_zero;
    logic tol_ok;
    logic at_limit;
    logic div_done;
    logic stable;
    logic out_full;
  } sts_t;

endpackage

// ===== design/nsr_regs.sv =====
module nsr_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [nsr_pkg::TolW-1:0]      tol_o,
  output logic [nsr_pkg::StepW-1:0]     max_o
);

  logic [nsr_pkg::TolW-1:0]  tol_q;
  logic [nsr_pkg::StepW-1:0] max_q;
  logic                      wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= nsr_pkg::TolReset;
      max_q <= nsr_pkg::MaxReset;
    end else if (wr) begin
      unique case (paddr)
        nsr_pkg::AddrTol: tol_q <= pwdata[nsr_pkg::TolW-1:0];
        nsr_pkg::AddrMax: max_q <= pwdata[nsr_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      nsr_pkg::AddrTol: prdata = 32'(tol_q);
      nsr_pkg::AddrMax: prdata = 32'(max_q);
      default:          prdata = '0;
    endcase
  end

  assign tol_o = tol_q;
  assign max_o = max_q;

endmodule

// ===== design/nsr_ctrl.sv =====
module nsr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  nsr_pkg::sts_t sts_i,
  output nsr_pkg::cmd_t cmd_o
);

  nsr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= nsr_pkg::StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nsr_pkg::StIdle:
        if (in_valid_i) state_d = sts_i.in_zero ? nsr_pkg::StFinish : nsr_pkg::StSquare;
      nsr_pkg::StSquare:  state_d = nsr_pkg::StCompare;
      nsr_pkg::StCompare: begin
        if (sts_i.tol_ok || sts_i.at_limit) state_d = nsr_pkg::StFinish;
        else                                state_d = nsr_pkg::StDivide;
      end
      nsr_pkg::StDivide:
        if (sts_i.div_done) state_d = nsr_pkg::StUpdate;
      nsr_pkg::StUpdate:
        state_d = sts_i.stable ? nsr_pkg::StFinish : nsr_pkg::StSquare;
      nsr_pkg::StFinish:
        if (!sts_i.out_full) state_d = nsr_pkg::StIdle;
      default: state_d = nsr_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      nsr_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.conv_we  = 1'b1;
          cmd_o.conv_val = 1'b1;
        end
      end
      nsr_pkg::StSquare: cmd_o.square = 1'b1;
      nsr_pkg::StCompare: begin
        if (sts_i.tol_ok) begin
          cmd_o.conv_we  = 1'b1;
          cmd_o.conv_val = 1'b1;
        end else if (sts_i.at_limit) begin
          cmd_o.conv_we  = 1'b1;
          cmd_o.conv_val = 1'b0;
        end else begin
          cmd_o.div_start = 1'b1;
        end
      end
      nsr_pkg::StDivide:
        if (!sts_i.div_done) cmd_o.div_step = 1'b1;
      nsr_pkg::StUpdate: begin
        cmd_o.update = 1'b1;
        if (sts_i.stable) begin
          cmd_o.conv_we  = 1'b1;
          cmd_o.conv_val = 1'b1;
        end
      end
      nsr_pkg::StFinish:
        if (!sts_i.out_full) cmd_o.finish = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== design/nsr_dp.sv =====
module nsr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [nsr_pkg::RadW-1:0]      radicand_i,
  input  logic [nsr_pkg::TolW-1:0]      tol_i,
  input  logic [nsr_pkg::StepW-1:0]     max_i,
  input  nsr_pkg::cmd_t                 cmd_i,
  output nsr_pkg::sts_t                 sts_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nsr_pkg::OutW-1:0]      out_data_o
);

  localparam int RW = nsr_pkg::RadW;
  localparam int SW = nsr_pkg::ScaledW;

  logic [SW-1:0]                 scaled_q;
  logic [RW-1:0]                 guess_q;
  logic [nsr_pkg::SqW-1:0]       sq_q;
  logic [RW-1:0]                 rem_q;
  logic [SW-1:0]                 quo_q;
  logic [nsr_pkg::DivCntW-1:0]   cnt_q;
  logic [nsr_pkg::StepW-1:0]     steps_q;
  logic                          conv_q;
  logic                          out_valid_q;
  logic [nsr_pkg::OutW-1:0]      out_q;

  logic [nsr_pkg::SqW-1:0] scaled_ext;
  logic [nsr_pkg::SqW-1:0] diff;
  logic [RW:0]             trial;
  logic                    take;
  logic [SW:0]             sum;
  logic [SW-1:0]           half;
  logic [RW-1:0]           next_guess;

  assign scaled_ext = nsr_pkg::SqW'(scaled_q);
  assign diff  = (sq_q >= scaled_ext) ? (sq_q - scaled_ext) : (scaled_ext - sq_q);
  assign trial = {rem_q, quo_q[SW-1]};
  assign take  = trial >= {1'b0, guess_q};
  assign sum   = {1'b0, quo_q} + (SW+1)'(guess_q);
  assign half  = sum[SW:1];
  // saturate a guess that no longer fits the result width
  assign next_guess = (|half[SW-1:RW]) ? {RW{1'b1}} : half[RW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      scaled_q <= {radicand_i, {nsr_pkg::FracBits{1'b0}}};
      guess_q  <= (radicand_i == '0) ? '0 : RW'(1) << nsr_pkg::FracBits;
      steps_q  <= '0;
    end
    if (cmd_i.square) sq_q <= guess_q * guess_q;
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= scaled_q;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= take ? RW'(trial - {1'b0, guess_q}) : trial[RW-1:0];
      quo_q <= {quo_q[SW-2:0], take};
      cnt_q <= cnt_q + 1'b1;
    end
    if (cmd_i.update) begin
      guess_q <= next_guess;
      steps_q <= steps_q + 1'b1;
    end
    if (cmd_i.conv_we) conv_q <= cmd_i.conv_val;
    if (cmd_i.finish) out_q <= nsr_pkg::OutW'({steps_q, conv_q, guess_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)            out_valid_q <= 1'b0;
    else if (cmd_i.finish)  out_valid_q <= 1'b1;
    else if (out_ready_i)   out_valid_q <= 1'b0;
  end

  assign sts_o.in_zero  = (radicand_i == '0);
  assign sts_o.tol_ok   = diff <= nsr_pkg::SqW'(tol_i);
  assign sts_o.at_limit = steps_q >= max_i;
  assign sts_o.div_done = (cnt_q == nsr_pkg::DivCntW'(SW));
  assign sts_o.stable   = (next_guess == guess_q);
  assign sts_o.out_full = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== design/newton_square_root_core.sv =====
// Newton-Raphson square root of an unsigned Q16.16 radicand, result in Q16.16
// with a converged flag and the number of Newton steps taken. One item is in
// work at a time. A zero radicand goes from its input beat straight to the
// result. Otherwise the item passes through accept, first square and first
// compare, then each Newton step through a bit-serial restoring division of 48
// shift steps and a done check, update, square and compare, and ends in the
// hand-off; an item that ends on a stable guess skips the last square and
// compare. The finished result sits in an output register until taken.
// tolerance (0x0) and max_iterations (0x4) must be written over the APB port
// only while the block is idle; the block itself does not enforce this.
module newton_square_root_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] radicand
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] root, [32] converged, [38:33] steps_used
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [nsr_pkg::TolW-1:0]  tol;
  logic [nsr_pkg::StepW-1:0] max_it;
  nsr_pkg::cmd_t             cmd;
  nsr_pkg::sts_t             sts;

  nsr_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .tol_o(tol), .max_o(max_it)
  );

  nsr_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  nsr_dp u_dp (
    .clk_i, .rst_ni,
    .radicand_i(s_axis_tdata), .tol_i(tol), .max_i(max_it),
    .cmd_i(cmd), .sts_o(sts),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(m_axis_tdata)
  );

endmodule

// ===== design/nsr_checker.sv =====
module nsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        pready
);

  // one item at a time: input closes right after a beat
  a_in_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // only a zero radicand yields a zero root, with no steps
  a_zero_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[31:0] == 32'd0)) |->
      (m_axis_tdata[32] && (m_axis_tdata[38:33] == 6'd0)))
    else $error("zero root without zero radicand path");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind newton_square_root_core nsr_checker u_chk (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [5:0]  steps;
    logic        conv;
    logic [31:0] root;
  } sqrt_res_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] radicand
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [31:0] root, [32] converged, [38:33] steps_used
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  newton_square_root_core u_dut (.*);

  logic [31:0] radicand_q[$];
  sqrt_res_t   root_q[$];
  logic [31:0] tol_r;
  logic [5:0]  max_r;
  int          send_idle_pct, recv_stall_pct;
  int          hold_off;
  int          mism;
  int          cycles;
  bit          sent_all;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Predict one result from the current register settings.
  function automatic sqrt_res_t predict_root(logic [31:0] rad);
    logic [63:0]  scaled, guess, nxt, q, sq, err;
    logic [5:0]   n;
    sqrt_res_t    r;
    scaled = {16'd0, rad, 16'd0};
    guess  = 64'h1_0000;
    n      = '0;
    r      = '0;
    if (rad == 0) begin
      r.conv = 1'b1;
      return r;
    end
    forever begin
      sq  = guess * guess;
      err = (sq >= scaled) ? sq - scaled : scaled - sq;
      if (err <= {32'd0, tol_r}) begin
        r.conv = 1'b1;
        break;
      end
      if (n >= max_r) begin
        r.conv = 1'b0;
        break;
      end
      q = (guess == 0) ? 64'h7FFF_FFFF_FFFF_FFFF : scaled / guess;
      if (q > 64'h7FFF_FFFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF_FFFF;
      nxt = (q + guess) >> 1;
      if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
      n++;
      if (nxt == guess) begin
        r.conv = 1'b1;
        break;
      end
      guess = nxt;
    end
    r.root  = guess[31:0];
    r.steps = n;
    return r;
  endfunction

  // Sender: take the next radicand from the queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        root_q.push_back(predict_root(s_axis_tdata));
        void'(radicand_q.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready)) begin
        if (radicand_q.size() > 0) begin
          if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
          end else begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= radicand_q[0];
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each result beat against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    sqrt_res_t exp_r;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (root_q.size() == 0) begin
          mism++;
          if (mism <= 10) $display("unexpected result %h", m_axis_tdata);
        end else begin
          exp_r = root_q.pop_front();
          if (m_axis_tdata[31:0] !== exp_r.root || m_axis_tdata[32] !== exp_r.conv ||
              m_axis_tdata[38:33] !== exp_r.steps) begin
            mism++;
            if (mism <= 10)
              $display("mismatch: exp root %h conv %0d steps %0d, got root %h conv %0d steps %0d",
                       exp_r.root, exp_r.conv, exp_r.steps, m_axis_tdata[31:0],
                       m_axis_tdata[32], m_axis_tdata[38:33]);
          end
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 20_000_000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == nsr_pkg::AddrTol) tol_r = data;
    else max_r = data[5:0];
  endtask

  task automatic drain;
    while (radicand_q.size() > 0 || root_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_radicand();
    case ($urandom_range(3))
      0: rand_radicand = $urandom;
      1: rand_radicand = $urandom_range(32'h3_0000);
      2: rand_radicand = 32'hFFFF_FFFF - $urandom_range(1000);
      default: rand_radicand = $urandom >> $urandom_range(31);
    endcase
  endfunction

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    repeat (n) radicand_q.push_back(rand_radicand());
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; m_axis_tready = 1'b0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    tol_r = nsr_pkg::TolReset; max_r = nsr_pkg::MaxReset;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 0; mism = 0; cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: extremes and special cases at reset settings
    radicand_q.push_back(32'd0);
    radicand_q.push_back(32'd1);
    radicand_q.push_back(32'h1_0000);
    radicand_q.push_back(32'h4_0000);
    radicand_q.push_back(32'hFFFF_FFFF);
    radicand_q.push_back(32'h8000_0000);
    radicand_q.push_back(32'h5555_5555);
    radicand_q.push_back(32'hAAAA_AAAA);
    radicand_q.push_back(32'h0000_0002);
    radicand_q.push_back(32'h0001_8000);
    drain();

    // zero step limit, then exact and oscillating cases with zero tolerance
    apb_write(nsr_pkg::AddrMax, 32'd0);
    radicand_q.push_back(32'h1_0000);
    radicand_q.push_back(32'h9_0000);
    radicand_q.push_back(32'd0);
    drain();
    apb_write(nsr_pkg::AddrTol, 32'd0);
    apb_write(nsr_pkg::AddrMax, 32'd63);
    radicand_q.push_back(32'h9_0000);
    radicand_q.push_back(32'h2_0000);
    radicand_q.push_back(32'h3_0000);
    radicand_q.push_back(32'hFFFF_FFFF);
    radicand_q.push_back(32'd3);
    drain();

    run_phase(120, 0, 0);
    apb_write(nsr_pkg::AddrTol, 32'hFFFF_FFFF);
    apb_write(nsr_pkg::AddrMax, 32'd1);
    run_phase(80, 72, 0);
    apb_write(nsr_pkg::AddrTol, $urandom);
    apb_write(nsr_pkg::AddrMax, 32'd3);
    run_phase(100, 0, 72);
    apb_write(nsr_pkg::AddrTol, 32'd42950);
    apb_write(nsr_pkg::AddrMax, 32'd40);
    run_phase(100, 28, 28);

    // long receiver hold-off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off = 3000;
    apb_write(nsr_pkg::AddrMax, 32'd5);
    run_phase(40, 0, 0);
    apb_write(nsr_pkg::AddrTol, 32'd1 << $urandom_range(31));
    apb_write(nsr_pkg::AddrMax, 32'($urandom_range(63, 1)));
    run_phase(140, 28, 28);

    if (mism == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
